// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of the console engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// File: hw/rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Geometry, codes and shared types of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Screen geometry.
  localparam int COLS        = 80;
  localparam int SCROLL_ROWS = 24;
  localparam int TOTAL_ROWS  = 25;

  localparam int NCELLS       = TOTAL_ROWS * COLS;
  localparam int SCROLL_LIMIT = SCROLL_ROWS * COLS;
  localparam int STATUS_BASE  = (TOTAL_ROWS - 1) * COLS;
  localparam int MOVE_CELLS   = (SCROLL_ROWS - 1) * COLS;

  // Internal widths.
  localparam int ADDR_W = $clog2(NCELLS);
  localparam int COL_W  = $clog2(COLS);
  localparam int CELL_W = 16;

  // Fixed field widths of the stream items.
  localparam int CMD_W   = 2;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 8;
  localparam int SCOL_W  = 7;
  localparam int IDX_W   = 11;
  localparam int POS_W   = 11;

  localparam int IN_FIELDS_W  = CHAR_W + COLOR_W + SCOL_W + IDX_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int RES_W        = POS_W + CHAR_W + COLOR_W;
  localparam int OUT_TDATA_W  = ((RES_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - RES_W;

  // Character and color constants.
  localparam logic [CHAR_W-1:0]  BLANK_CHAR  = 8'h20;
  localparam logic [CHAR_W-1:0]  CHAR_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0]  CHAR_CR     = 8'h0D;
  localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h09;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_PUT    = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_STATUS = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  // One input item.
  typedef struct packed {
    cmd_t                cmd;
    logic [IDX_W-1:0]    cell_index;
    logic [SCOL_W-1:0]   status_col;
    logic [COLOR_W-1:0]  color;
    logic [CHAR_W-1:0]   char_code;
  } item_t;

  // One result item, cursor in the low bits.
  typedef struct packed {
    logic [COLOR_W-1:0]  cell_color;
    logic [CHAR_W-1:0]   cell_char;
    logic [POS_W-1:0]    cursor_pos;
  } res_t;

  // Write request into the cell store.
  typedef struct packed {
    logic                we;
    logic [ADDR_W-1:0]   addr;
    logic [CELL_W-1:0]   data;
  } ram_wr_t;

  // Read request into the cell store.
  typedef struct packed {
    logic                re;
    logic [ADDR_W-1:0]   addr;
  } ram_rd_t;

endpackage

// File: hw/rtl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console engine over a cell store with cursor, scrolling area,
// status row and cell readback.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Beat contents (low bits first)
//  s_*      in   tuser: cmd; tdata: char_code, color, status_col, cell_index
//  m_*      out  tdata: cursor_pos, cell_char, cell_color
//  cfg_*    in   data: blank_color
//
//  A put, a status write or a newline goes from idle to the result state,
//  a read in range via a read state. A put that scrolls walks the store with
//  one shared address counter: it moves the scrolling rows up one row, then
//  blanks the last scrolling row. A clear blanks all NCELLS cells; s_tready
//  is low meanwhile. After reset a clearing pass over all cells runs before
//  the first item is taken; configuration writes are taken at any time.
//  A result waits in the output register while the next item is taken.
//
module text_console_writer (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // tdata: char_code, color, status_col, cell_index, zero fill
  input  logic [tcw_pkg::IN_TDATA_W-1:0]       s_tdata,
  // tuser: cmd
  input  logic [tcw_pkg::CMD_W-1:0]            s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // tdata: cursor_pos, cell_char, cell_color, zero fill
  output logic [tcw_pkg::OUT_TDATA_W-1:0]      m_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tcw_pkg::COLOR_W-1:0]          cfg_data
);

  logic [tcw_pkg::COLOR_W-1:0] blank_color;
  tcw_pkg::item_t              item;
  tcw_pkg::ram_wr_t            ram_wr;
  tcw_pkg::ram_rd_t            ram_rd;
  logic [tcw_pkg::CELL_W-1:0]  ram_rdata;
  logic                        res_valid;
  logic                        res_ready;
  tcw_pkg::res_t               res;
  tcw_pkg::res_t               out_res;

  // Unpack the input beat.
  assign item.cmd        = tcw_pkg::cmd_t'(s_tuser);
  assign item.char_code  = s_tdata[tcw_pkg::CHAR_W-1:0];
  assign item.color      = s_tdata[tcw_pkg::CHAR_W +: tcw_pkg::COLOR_W];
  assign item.status_col = s_tdata[tcw_pkg::CHAR_W + tcw_pkg::COLOR_W +: tcw_pkg::SCOL_W];
  assign item.cell_index = s_tdata[tcw_pkg::CHAR_W + tcw_pkg::COLOR_W + tcw_pkg::SCOL_W +:
                                   tcw_pkg::IDX_W];

  // Blank color register; always writable.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blank_color <= tcw_pkg::RESET_COLOR;
    end else if (cfg_valid) begin
      blank_color <= cfg_data;
    end
  end

  // Cell store, character in the low byte and color in the high byte.
  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (tcw_pkg::NCELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_wr.we),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .re    (ram_rd.re),
    .raddr (ram_rd.addr),
    .rdata (ram_rdata)
  );

  tcw_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_item     (item),
    .blank_color (blank_color),
    .ram_wr      (ram_wr),
    .ram_rd      (ram_rd),
    .ram_rdata   (ram_rdata),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // Output register.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_tdata = {{tcw_pkg::OUT_PAD_W{1'b0}}, out_res};

endmodule

// File: hw/rtl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/tcw_seq.sv
// ----------------------------------------------------------------------------
// tcw_seq
// Command sequencer: cursor tracking and a shared address counter that walks
// the cell store for the power-up fill, clear, scroll copy and row blanking.
// ----------------------------------------------------------------------------
module tcw_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tcw_pkg::item_t                in_item,
  input  logic [tcw_pkg::COLOR_W-1:0]   blank_color,
  output tcw_pkg::ram_wr_t              ram_wr,
  output tcw_pkg::ram_rd_t              ram_rd,
  input  logic [tcw_pkg::CELL_W-1:0]    ram_rdata,
  output logic                          res_valid,
  input  logic                          res_ready,
  output tcw_pkg::res_t                 res
);

  typedef enum logic [5:0] {
    ST_INIT = 6'b000001,
    ST_IDLE = 6'b000010,
    ST_READ = 6'b000100,
    ST_COPY = 6'b001000,
    ST_FILL = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  localparam logic [tcw_pkg::ADDR_W-1:0] A_COLS     = tcw_pkg::ADDR_W'(tcw_pkg::COLS);
  localparam logic [tcw_pkg::ADDR_W-1:0] A_LIMIT    = tcw_pkg::ADDR_W'(tcw_pkg::SCROLL_LIMIT);
  localparam logic [tcw_pkg::ADDR_W-1:0] A_LAST     = tcw_pkg::ADDR_W'(tcw_pkg::NCELLS - 1);
  localparam logic [tcw_pkg::ADDR_W-1:0] A_STATUS   = tcw_pkg::ADDR_W'(tcw_pkg::STATUS_BASE);
  localparam logic [tcw_pkg::ADDR_W-1:0] A_MOVE     = tcw_pkg::ADDR_W'(tcw_pkg::MOVE_CELLS);
  localparam logic [tcw_pkg::COL_W-1:0]  C_LAST     = tcw_pkg::COL_W'(tcw_pkg::COLS - 1);

  state_t                         state, state_next;
  logic [tcw_pkg::ADDR_W-1:0]     ptr, ptr_next;
  logic [tcw_pkg::ADDR_W-1:0]     fill_end, fill_end_next;
  logic [tcw_pkg::COLOR_W-1:0]    fill_color, fill_color_next;
  logic [tcw_pkg::ADDR_W-1:0]     cursor, cursor_next;
  logic [tcw_pkg::COL_W-1:0]      col, col_next;
  logic                           cp_pend, cp_pend_next;
  logic [tcw_pkg::ADDR_W-1:0]     cp_dst, cp_dst_next;
  logic                           drain, drain_next;
  logic [tcw_pkg::CHAR_W-1:0]     res_char, res_char_next;
  logic [tcw_pkg::COLOR_W-1:0]    res_color, res_color_next;

  logic                           is_nl;
  logic [tcw_pkg::ADDR_W-1:0]     put_cursor;
  logic [tcw_pkg::COL_W-1:0]      put_col;
  logic                           put_scroll;
  logic                           scol_ok;
  logic                           idx_ok;
  logic [tcw_pkg::ADDR_W-1:0]     ptr_inc;

  // Shared address counter step.
  assign ptr_inc = ptr + tcw_pkg::ADDR_W'(1);

  // Cursor move of a put: newline goes to the next row start, anything else
  // advances one cell with the column wrapping at the row end.
  assign is_nl      = (in_item.char_code == tcw_pkg::CHAR_LF) ||
                      (in_item.char_code == tcw_pkg::CHAR_CR);
  assign put_cursor = is_nl ? (cursor - tcw_pkg::ADDR_W'(col) + A_COLS)
                            : (cursor + tcw_pkg::ADDR_W'(1));
  assign put_col    = (is_nl || col == C_LAST) ? '0 : col + tcw_pkg::COL_W'(1);
  assign put_scroll = (put_cursor >= A_LIMIT);

  // Range checks of the status column and the read index.
  assign scol_ok = (int'(in_item.status_col) < tcw_pkg::COLS);
  assign idx_ok  = (int'(in_item.cell_index) < tcw_pkg::NCELLS);

  // Sequencer.
  always_comb begin
    state_next      = state;
    ptr_next        = ptr;
    fill_end_next   = fill_end;
    fill_color_next = fill_color;
    cursor_next     = cursor;
    col_next        = col;
    cp_pend_next    = 1'b0;
    cp_dst_next     = cp_dst;
    drain_next      = drain;
    res_char_next   = res_char;
    res_color_next  = res_color;
    ram_wr          = '0;
    ram_rd.re       = 1'b0;
    ram_rd.addr     = ptr;
    in_ready        = 1'b0;
    res_valid       = 1'b0;

    case (state)
      ST_INIT, ST_FILL: begin
        ram_wr.we   = 1'b1;
        ram_wr.addr = ptr;
        ram_wr.data = {fill_color, tcw_pkg::BLANK_CHAR};
        if (ptr == fill_end) begin
          state_next = (state == ST_INIT) ? ST_IDLE : ST_DONE;
        end else begin
          ptr_next = ptr_inc;
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          res_char_next  = '0;
          res_color_next = '0;
          state_next     = ST_DONE;
          case (in_item.cmd)
            tcw_pkg::CMD_PUT: begin
              if (!is_nl) begin
                ram_wr.we   = 1'b1;
                ram_wr.addr = cursor;
                ram_wr.data = {in_item.color, in_item.char_code};
              end
              col_next = put_col;
              if (put_scroll) begin
                cursor_next = put_cursor - A_COLS;
                ptr_next    = A_COLS;
                drain_next  = 1'b0;
                state_next  = ST_COPY;
              end else begin
                cursor_next = put_cursor;
              end
            end
            tcw_pkg::CMD_CLEAR: begin
              cursor_next     = '0;
              col_next        = '0;
              ptr_next        = '0;
              fill_end_next   = A_LAST;
              fill_color_next = blank_color;
              state_next      = ST_FILL;
            end
            tcw_pkg::CMD_STATUS: begin
              ram_wr.we   = scol_ok;
              ram_wr.addr = A_STATUS + tcw_pkg::ADDR_W'(in_item.status_col);
              ram_wr.data = {in_item.color, in_item.char_code};
            end
            tcw_pkg::CMD_READ: begin
              if (idx_ok) begin
                ram_rd.re   = 1'b1;
                ram_rd.addr = tcw_pkg::ADDR_W'(in_item.cell_index);
                state_next  = ST_READ;
              end
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end

      ST_READ: begin
        res_char_next  = ram_rdata[tcw_pkg::CHAR_W-1:0];
        res_color_next = ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
        state_next     = ST_DONE;
      end

      // Scroll copy: read a cell one row below, write it one row up in the next cycle.
      ST_COPY: begin
        ram_wr.we   = cp_pend;
        ram_wr.addr = cp_dst;
        ram_wr.data = ram_rdata;
        if (!drain) begin
          ram_rd.re    = 1'b1;
          ram_rd.addr  = ptr;
          cp_pend_next = 1'b1;
          cp_dst_next  = ptr - A_COLS;
          if (ptr == A_LIMIT - tcw_pkg::ADDR_W'(1)) begin
            drain_next = 1'b1;
          end else begin
            ptr_next = ptr_inc;
          end
        end else begin
          drain_next      = 1'b0;
          ptr_next        = A_MOVE;
          fill_end_next   = A_LIMIT - tcw_pkg::ADDR_W'(1);
          fill_color_next = blank_color;
          state_next      = ST_FILL;
        end
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      ptr        <= '0;
      fill_end   <= A_LAST;
      fill_color <= tcw_pkg::RESET_COLOR;
      cursor     <= '0;
      col        <= '0;
      cp_pend    <= 1'b0;
      drain      <= 1'b0;
    end else begin
      state      <= state_next;
      ptr        <= ptr_next;
      fill_end   <= fill_end_next;
      fill_color <= fill_color_next;
      cursor     <= cursor_next;
      col        <= col_next;
      cp_pend    <= cp_pend_next;
      drain      <= drain_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cp_dst    <= cp_dst_next;
    res_char  <= res_char_next;
    res_color <= res_color_next;
  end

  assign res.cursor_pos = tcw_pkg::POS_W'(cursor);
  assign res.cell_char  = res_char;
  assign res.cell_color = res_color;

endmodule

// File: hw/rtl/tcw_chk.sv
// ----------------------------------------------------------------------------
// tcw_chk
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcw_chk (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic [tcw_pkg::IN_TDATA_W-1:0]   s_tdata,
  input logic [tcw_pkg::CMD_W-1:0]        s_tuser,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [tcw_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic [tcw_pkg::COLOR_W-1:0]      cfg_data
);

  // A stalled result beat holds.
  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // Every item keeps the block busy: s_tready goes low after an item is taken.
  `ASSERT_NEXT(a_busy_after_take, clk, rst, s_tvalid && s_tready, !s_tready)

  // The cursor never leaves the scrolling area.
  `ASSERT_IMPLIES(a_cursor_range, clk, rst, m_tvalid, int'(m_tdata[tcw_pkg::POS_W-1:0]) < tcw_pkg::SCROLL_LIMIT)

  // Fill bits of the result beat stay zero.
  `ASSERT_IMPLIES(a_pad_zero, clk, rst, m_tvalid, m_tdata[tcw_pkg::OUT_TDATA_W-1:tcw_pkg::RES_W] == '0)

endmodule

bind text_console_writer tcw_chk u_tcw_chk (.*);
